// ===== src/ccfr_pkg.sv =====
`timescale 1ns / 1ps

package ccfr_pkg;

  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h8408;
  localparam logic [8:0]  MinEndIdx = 9'd4;

  localparam logic [7:0] CMD_21 = 8'h21;
  localparam logic [7:0] CMD_24 = 8'h24;
  localparam logic [7:0] CMD_2F = 8'h2F;
  localparam logic [7:0] CMD_22 = 8'h22;
  localparam logic [7:0] CMD_28 = 8'h28;
  localparam logic [7:0] CMD_25 = 8'h25;

  typedef enum logic [2:0] {
    RPL_21,
    RPL_24,
    RPL_2F,
    RPL_22,
    RPL_28,
    RPL_25
  } reply_kind_e;

  typedef struct packed {
    logic        start;
    reply_kind_e kind;
  } reply_req_t;

  localparam logic [3:0] LastIdxLong  = 4'd13;
  localparam logic [3:0] LastIdxShort = 4'd5;

  function automatic logic [3:0] reply_last_idx(input reply_kind_e kind);
    return (kind == RPL_21) ? LastIdxLong : LastIdxShort;
  endfunction

  // six-byte replies share one layout: 05 00 cmd 00 crc_lo crc_hi
  function automatic logic [23:0] short_reply_fields(input reply_kind_e kind);
    logic [23:0] f;
    case (kind)
      RPL_24:  f = {CMD_24, 8'h25, 8'h29};
      RPL_2F:  f = {CMD_2F, 8'h8D, 8'hCD};
      RPL_22:  f = {CMD_22, 8'hF5, 8'h7D};
      RPL_28:  f = {CMD_28, 8'h85, 8'h80};
      RPL_25:  f = {CMD_25, 8'hFD, 8'h30};
      default: f = 24'h0;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] reply_byte(input reply_kind_e kind, input logic [3:0] idx);
    logic [7:0]  b;
    logic [23:0] f;
    f = short_reply_fields(kind);
    if (kind == RPL_21) begin
      case (idx)
        4'd0:    b = 8'h0D;
        4'd1:    b = 8'h00;
        4'd2:    b = 8'h21;
        4'd3:    b = 8'h00;
        4'd4:    b = 8'h02;
        4'd5:    b = 8'h44;
        4'd6:    b = 8'h09;
        4'd7:    b = 8'h03;
        4'd8:    b = 8'h4E;
        4'd9:    b = 8'h00;
        4'd10:   b = 8'h1E;
        4'd11:   b = 8'h0A;
        4'd12:   b = 8'hF2;
        4'd13:   b = 8'h16;
        default: b = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    b = 8'h05;
        4'd1:    b = 8'h00;
        4'd2:    b = f[23:16];
        4'd3:    b = 8'h00;
        4'd4:    b = f[15:8];
        4'd5:    b = f[7:0];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== src/ccfr_rx_if.sv =====
`timescale 1ns / 1ps

interface ccfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ccfr_tx_if.sv =====
`timescale 1ns / 1ps

interface ccfr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       reply_last;

  modport source (output valid, output tx_byte, output reply_last, input ready);
  modport sink (input valid, input tx_byte, input reply_last, output ready);
endinterface

// ===== src/crc_checked_frame_responder.sv =====
`timescale 1ns / 1ps
// a reply starts when the frame's last byte is taken: burst register, then output register
// throughput: one rx byte per cycle; rx stalls while a reply burst of 6 or 14 bytes
//   is loaded into the output register, one byte per cycle when tx is ready
// the single output register lets rx keep flowing while the final reply byte waits
// reset: asynchronous, active low; parser waits for a length byte, crc preset, tx empty

module crc_checked_frame_responder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccfr_rx_if.sink   rx_i,
  ccfr_tx_if.source tx_o
);
  import ccfr_pkg::*;

  reply_req_t req;
  logic       busy;
  logic       rx_accept;

  assign rx_i.ready = !busy;
  assign rx_accept  = rx_i.valid && !busy;

  ccfr_frame_rx u_frame_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_i.rx_byte),
    .req_o     (req)
  );

  ccfr_reply_tx u_reply_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (busy),
    .tx_o   (tx_o)
  );

  // a new reply never starts on top of a running burst
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !busy)
    else $error("reply started during burst");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> busy)
    else $error("reply request lost");

  // an empty output register is filled at once while a burst runs
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !tx_o.valid) |=> tx_o.valid)
    else $error("burst stalled with empty output");

endmodule

// ===== src/ccfr_frame_rx.sv =====
`timescale 1ns / 1ps

module ccfr_frame_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output ccfr_pkg::reply_req_t req_o
);
  import ccfr_pkg::*;

  logic        in_frame_q, in_frame_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  rb0_q, rb0_d;
  logic [7:0]  rb1_q, rb1_d;
  logic [7:0]  cmd_q, cmd_d;

  logic [15:0] crc_next;
  logic        is_end;
  logic        crc_ok;
  logic        known;
  reply_kind_e kind;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // crc trails the input by two bytes, so fold in the older buffered byte
  assign crc_next = crc_step(crc_q, rb1_q);
  assign is_end   = (cnt_q == {1'b0, len_q});
  assign crc_ok   = (rb0_q == crc_next[7:0]) && (rx_byte_i == crc_next[15:8]);

  always_comb begin
    known = 1'b1;
    kind  = RPL_21;
    case (cmd_q)
      CMD_21:  kind = RPL_21;
      CMD_24:  kind = RPL_24;
      CMD_2F:  kind = RPL_2F;
      CMD_22:  kind = RPL_22;
      CMD_28:  kind = RPL_28;
      CMD_25:  kind = RPL_25;
      default: known = 1'b0;
    endcase
  end

  // command byte sits at index 2, well before any end index of 4 or more
  assign req_o.start = accept_i && in_frame_q && is_end && (cnt_q >= MinEndIdx) &&
                       crc_ok && known;
  assign req_o.kind  = kind;

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    crc_d      = crc_q;
    rb0_d      = rb0_q;
    rb1_d      = rb1_q;
    cmd_d      = cmd_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        crc_d      = CrcPreset;
        rb0_d      = rx_byte_i;
        rb1_d      = 8'h00;
        len_d      = rx_byte_i;
        in_frame_d = (rx_byte_i != 8'h00);
        cnt_d      = (rx_byte_i != 8'h00) ? 9'd1 : 9'd0;
      end else begin
        if (cnt_q >= 9'd2) begin
          crc_d = crc_next;
        end
        rb1_d = rb0_q;
        rb0_d = rx_byte_i;
        if (cnt_q == 9'd2) begin
          cmd_d = rx_byte_i;
        end
        if (is_end) begin
          in_frame_d = 1'b0;
          cnt_d      = 9'd0;
        end else begin
          cnt_d = cnt_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= 9'd0;
      len_q      <= 8'h00;
      crc_q      <= CrcPreset;
      rb0_q      <= 8'h00;
      rb1_q      <= 8'h00;
      cmd_q      <= 8'h00;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      crc_q      <= crc_d;
      rb0_q      <= rb0_d;
      rb1_q      <= rb1_d;
      cmd_q      <= cmd_d;
    end
  end

endmodule

// ===== src/ccfr_reply_tx.sv =====
`timescale 1ns / 1ps

module ccfr_reply_tx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccfr_pkg::reply_req_t req_i,
  output logic                 busy_o,
  ccfr_tx_if.source            tx_o
);
  import ccfr_pkg::*;

  logic        burst_q;
  reply_kind_e kind_q;
  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        load;
  logic        at_last;

  assign at_last = (idx_q == reply_last_idx(kind_q));
  // during a burst, refill the output register when it is empty or its transaction completes
  assign load    = burst_q && (!out_valid_q || tx_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q     <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
      kind_q      <= RPL_21;
    end else begin
      if (req_i.start) begin
        burst_q <= 1'b1;
        kind_q  <= req_i.kind;
        idx_q   <= 4'd0;
      end else if (load) begin
        if (at_last) begin
          burst_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= reply_byte(kind_q, idx_q);
      out_last_q <= at_last;
    end
  end

  assign busy_o          = burst_q;
  assign tx_o.valid      = out_valid_q;
  assign tx_o.tx_byte    = out_byte_q;
  assign tx_o.reply_last = out_last_q;

endmodule

// ===== tb/ccfr_reply_checker.sv =====
`timescale 1ns / 1ps

module ccfr_reply_checker
  import ccfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic       rx_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       tx_valid_i,
  input  logic       tx_ready_i,
  input  logic [7:0] tx_byte_i,
  input  logic       tx_last_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } reply_beat_t;

  reply_beat_t reply_beats_q[$];

  // shadow of the frame parser
  logic        in_frame;
  logic [8:0]  byte_cnt;
  logic [7:0]  frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  newest_byte;
  logic [7:0]  older_byte;
  logic [7:0]  cmd_code;

  always @(posedge clk_i or negedge rst_ni) begin : track_frames
    reply_beat_t  beat;
    logic [8:0]   idx;
    logic [111:0] image;
    int           n;
    if (!rst_ni) begin
      in_frame     = 1'b0;
      byte_cnt     = '0;
      frame_len    = '0;
      crc_acc      = CrcPreset;
      newest_byte  = '0;
      older_byte   = '0;
      cmd_code     = '0;
      fail_count_o = 0;
      reply_beats_q.delete();
      pending_o    = 0;
    end else begin
      // reply side first: a reply never leaves in the cycle its frame ends
      if (tx_valid_i && tx_ready_i) begin
        if (reply_beats_q.size() == 0) begin
          $display("%0t: unexpected reply byte %02h last %0b", $time, tx_byte_i, tx_last_i);
          fail_count_o++;
        end else begin
          beat = reply_beats_q.pop_front();
          if (beat.tx_byte !== tx_byte_i || beat.last !== tx_last_i) begin
            $display("%0t: reply mismatch, expected %02h last %0b, got %02h last %0b",
                     $time, beat.tx_byte, beat.last, tx_byte_i, tx_last_i);
            fail_count_o++;
          end
        end
      end

      if (rx_valid_i && rx_ready_i) begin
        if (!in_frame) begin
          crc_acc     = CrcPreset;
          newest_byte = rx_byte_i;
          older_byte  = '0;
          frame_len   = rx_byte_i;
          // a zero length byte is a whole frame by itself
          in_frame    = (rx_byte_i != 8'h00);
          byte_cnt    = in_frame ? 9'd1 : 9'd0;
        end else begin
          idx = byte_cnt;
          // crc trails the input by two bytes
          if (idx >= 9'd2) begin
            crc_acc = crc_acc ^ {8'h00, older_byte};
            for (int k = 0; k < 8; k++) begin
              crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CrcPoly) : (crc_acc >> 1);
            end
          end
          older_byte  = newest_byte;
          newest_byte = rx_byte_i;
          if (idx == 9'd2) cmd_code = rx_byte_i;
          byte_cnt = idx + 9'd1;

          if (idx == {1'b0, frame_len}) begin
            in_frame = 1'b0;
            byte_cnt = '0;
            if (idx >= MinEndIdx && older_byte == crc_acc[7:0] &&
                newest_byte == crc_acc[15:8]) begin
              case (cmd_code)
                CMD_21: begin
                  n = 14;
                  image = 112'h0D00_2100_0244_0903_4E00_1E0A_F216;
                end
                CMD_24: begin n = 6; image = {48'h0500_2400_2529, 64'h0}; end
                CMD_2F: begin n = 6; image = {48'h0500_2F00_8DCD, 64'h0}; end
                CMD_22: begin n = 6; image = {48'h0500_2200_F57D, 64'h0}; end
                CMD_28: begin n = 6; image = {48'h0500_2800_8580, 64'h0}; end
                CMD_25: begin n = 6; image = {48'h0500_2500_FD30, 64'h0}; end
                default: begin n = 0; image = '0; end
              endcase
              for (int k = 0; k < n; k++) begin
                beat.tx_byte = image[111 - 8 * k -: 8];
                beat.last    = (k == n - 1);
                reply_beats_q.push_back(beat);
              end
            end
          end
        end
      end
      pending_o = reply_beats_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ccfr_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int sender_idle_pct = 13;
  int recv_idle_pct   = 63;
  int sent_bytes      = 0;
  int fail_count;
  int pending;

  ccfr_rx_if rx_bus ();
  ccfr_tx_if tx_bus ();

  crc_checked_frame_responder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .tx_o   (tx_bus)
  );

  ccfr_reply_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_bus.valid),
    .rx_ready_i   (rx_bus.ready),
    .rx_byte_i    (rx_bus.rx_byte),
    .tx_valid_i   (tx_bus.valid),
    .tx_ready_i   (tx_bus.ready),
    .tx_byte_i    (tx_bus.tx_byte),
    .tx_last_i    (tx_bus.reply_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    tx_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] known_code();
    case ($urandom_range(5))
      0:       return CMD_21;
      1:       return CMD_24;
      2:       return CMD_2F;
      3:       return CMD_22;
      4:       return CMD_28;
      default: return CMD_25;
    endcase
  endfunction

  // sends length byte, filler, command at index 2 and the trailing crc pair;
  // a bad frame gets one of the crc bytes flipped
  task automatic send_frame(input int len, input logic [7:0] code, input bit good);
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  flip;
    bit          flip_hi;
    crc     = CrcPreset;
    flip    = good ? 8'h00 : 8'($urandom_range(1, 255));
    flip_hi = 1'($urandom_range(1));
    for (int i = 0; i <= len; i++) begin
      if (i == 0) b = 8'(len);
      else if (i == len - 1) b = crc[7:0] ^ (flip_hi ? 8'h00 : flip);
      else if (i == len) b = crc[15:8] ^ (flip_hi ? flip : 8'h00);
      else if (i == 2) b = code;
      else b = 8'($urandom_range(255));

      while ($urandom_range(99) < sender_idle_pct) begin
        rx_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
      rx_bus.valid   <= 1'b1;
      rx_bus.rx_byte <= b;
      @(posedge clk_i);
      while (!rx_bus.ready) @(posedge clk_i);
      sent_bytes++;

      if (i <= len - 2) begin
        crc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
          crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
        end
      end
    end
  endtask

  task automatic random_frames(input int byte_goal);
    int stop_at;
    int pick;
    int len;
    stop_at = sent_bytes + byte_goal;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(4, 10);
      if (pick < 55) send_frame(len, known_code(), 1'b1);
      else if (pick < 65) send_frame(len, 8'($urandom_range(255)), 1'b1);
      else if (pick < 77) send_frame(len, known_code(), 1'b0);
      else if (pick < 87) send_frame($urandom_range(3), known_code(), 1'($urandom_range(1)));
      else send_frame($urandom_range(20), 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // hold the input off until every reply has drained
  task automatic wait_replies_done();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_frame(0, 8'h00, 1'b1);
    send_frame(3, CMD_21, 1'b1);
    send_frame(4, CMD_21, 1'b1);
    send_frame(4, CMD_24, 1'b1);
    send_frame(4, CMD_2F, 1'b1);
    send_frame(4, CMD_22, 1'b1);
    send_frame(4, CMD_28, 1'b1);
    send_frame(4, CMD_25, 1'b1);
    send_frame(4, CMD_24, 1'b0);
    send_frame(4, 8'hFF, 1'b1);

    random_frames(40);
    wait_replies_done();
    repeat (5) @(posedge clk_i);

    sender_idle_pct = 63;
    recv_idle_pct   = 13;
    random_frames(40);
    wait_replies_done();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    send_frame(255, CMD_21, 1'b1);
    random_frames(30);
    wait_replies_done();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ccfr_pkg.sv
src/ccfr_rx_if.sv
src/ccfr_tx_if.sv
src/ccfr_frame_rx.sv
src/ccfr_reply_tx.sv
src/crc_checked_frame_responder.sv
tb/ccfr_reply_checker.sv
tb/tb_top.sv
